// ===== hw/rtl/stis_pkg.sv =====
package stis_pkg;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  localparam logic [1:0] ST_INSERTED  = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [15:0] key;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] position;
    logic [7:0] fill_count;
  } rsp_t;

endpackage

// ===== hw/rtl/sorted_table_insert_search.sv =====
// Channel | Signals                       | Payload
// req     | req_valid, req_ready, req     | cmd, key
// rsp     | rsp_valid, rsp_ready, rsp     | status, position, fill_count
//
// An insert moves one larger entry up per cycle while the key walks down from
// the top; the table has a read port and a write port, so the next lower entry
// is fetched while the current one moves. A search spends each binary step in
// BS_CHK, which issues the read, and BS_CMP, which compares the registered data.
// Reset clears the state, rsp_valid and the fill count; the table needs no clearing pass.
// A finished result waits in the output register while rsp_ready is low.
module sorted_table_insert_search #(
  parameter int DEPTH = 128
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  stis_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output stis_pkg::rsp_t rsp
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    IDLE,
    SHIFT,
    BS_CHK,
    BS_CMP,
    EQ_CHK,
    FIN
  } state_t;

  state_t state;

  logic [15:0]   mem [DEPTH];
  logic [15:0]   rdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  logic [CW-1:0] count;
  logic [CW-1:0] p;
  logic [CW-1:0] lo;
  logic [CW-1:0] hi;
  logic [CW-1:0] mid;
  logic [15:0]   key_r;
  logic [1:0]    res_status;
  logic [CW-1:0] res_pos;

  logic [CW-1:0] count_m1;
  logic [CW-1:0] p_m2;
  logic [CW-1:0] mid_calc;
  logic          shift;

  assign req_ready = (state == IDLE);
  assign count_m1  = count - CW'(1);
  assign p_m2      = p - CW'(2);
  assign mid_calc  = lo + ((hi - lo) >> 1);
  assign shift     = (p != '0) && (key_r < rdata);

  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = '0;
    mem_we    = 1'b0;
    mem_waddr = p[AW-1:0];
    mem_wdata = shift ? rdata : key_r;
    case (state)
      IDLE: begin
        if (req_valid && req.cmd == stis_pkg::CMD_INSERT && count != '0) begin
          mem_re    = 1'b1;
          mem_raddr = count_m1[AW-1:0];
        end
      end
      SHIFT: begin
        mem_we = 1'b1;
        // Fetch the next lower entry while this one moves up.
        if (shift) begin
          mem_re    = 1'b1;
          mem_raddr = p_m2[AW-1:0];
        end
      end
      BS_CHK: begin
        if (lo < hi) begin
          mem_re    = 1'b1;
          mem_raddr = mid_calc[AW-1:0];
        end else if (lo < count) begin
          mem_re    = 1'b1;
          mem_raddr = lo[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (rsp_valid && rsp_ready && state != FIN) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (req_valid) begin
            key_r <= req.key;
            if (req.cmd == stis_pkg::CMD_INSERT) begin
              if (count == CW'(DEPTH)) begin
                res_status <= stis_pkg::ST_FULL;
                res_pos    <= '0;
                state      <= FIN;
              end else begin
                p     <= count;
                state <= SHIFT;
              end
            end else begin
              lo    <= '0;
              hi    <= count;
              state <= BS_CHK;
            end
          end
        end
        SHIFT: begin
          if (shift) begin
            p <= p - CW'(1);
          end else begin
            res_status <= stis_pkg::ST_INSERTED;
            res_pos    <= p;
            count      <= count + CW'(1);
            state      <= FIN;
          end
        end
        BS_CHK: begin
          if (lo < hi) begin
            mid   <= mid_calc;
            state <= BS_CMP;
          end else if (lo < count) begin
            state <= EQ_CHK;
          end else begin
            res_status <= stis_pkg::ST_NOT_FOUND;
            res_pos    <= '0;
            state      <= FIN;
          end
        end
        BS_CMP: begin
          if (rdata < key_r) begin
            lo <= mid + CW'(1);
          end else begin
            hi <= mid;
          end
          state <= BS_CHK;
        end
        EQ_CHK: begin
          if (rdata == key_r) begin
            res_status <= stis_pkg::ST_FOUND;
            res_pos    <= lo;
          end else begin
            res_status <= stis_pkg::ST_NOT_FOUND;
            res_pos    <= '0;
          end
          state <= FIN;
        end
        FIN: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.position    <= 7'(res_pos);
            rsp.fill_count  <= 8'(count);
            state           <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/stis_checker.sv =====
module stis_checker #(
  parameter int DEPTH = 128
) (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input stis_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input stis_pkg::rsp_t rsp
);

  // A stalled response must hold its payload.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("response changed while stalled");

  // The block never accepts a request in the cycle after it accepted one.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken on consecutive cycles");

  // Full and not-found results carry a zero position.
  a_pos_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == stis_pkg::ST_FULL ||
                  rsp.status == stis_pkg::ST_NOT_FOUND) |-> rsp.position == '0)
    else $error("nonzero position on full or not-found result");

  // The fill count never goes past the table depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && DEPTH < 256 |-> rsp.fill_count <= DEPTH)
    else $error("fill count above depth");

  // An inserted key lands inside the filled part of the table.
  a_ins_pos: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status == stis_pkg::ST_INSERTED && DEPTH <= 128 |->
    8'(rsp.position) < rsp.fill_count)
    else $error("insert position outside filled entries");

endmodule

bind sorted_table_insert_search stis_checker #(.DEPTH(DEPTH)) u_stis_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

// ===== tb/sv/sorted_table_insert_search_tb.sv =====
module sorted_table_insert_search_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 128;
  localparam int STALL_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 96;
  localparam int DIRECTED_ROWS = 20;

  // One row of the directed table. When checked_here is set, the typed
  // outcome is awaited; otherwise the shadow table supplies it.
  typedef struct packed {
    stis_pkg::req_t stim;
    logic checked_here;
    stis_pkg::rsp_t outcome;
  } directed_row_t;

  localparam stis_pkg::rsp_t FROM_SHADOW = '0;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    {stis_pkg::CMD_SEARCH, 16'h0000, 1'b1, stis_pkg::ST_NOT_FOUND, 7'd0, 8'd0},
    {stis_pkg::CMD_SEARCH, 16'hFFFF, 1'b1, stis_pkg::ST_NOT_FOUND, 7'd0, 8'd0},
    {stis_pkg::CMD_INSERT, 16'h8000, 1'b1, stis_pkg::ST_INSERTED, 7'd0, 8'd1},
    {stis_pkg::CMD_INSERT, 16'h0000, 1'b1, stis_pkg::ST_INSERTED, 7'd0, 8'd2},
    {stis_pkg::CMD_INSERT, 16'hFFFF, 1'b1, stis_pkg::ST_INSERTED, 7'd2, 8'd3},
    {stis_pkg::CMD_INSERT, 16'h8000, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_SEARCH, 16'h8000, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_SEARCH, 16'hFFFF, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_SEARCH, 16'h0000, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_SEARCH, 16'h1234, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_INSERT, 16'hFFFF, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_INSERT, 16'h0000, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_SEARCH, 16'hFFFF, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_SEARCH, 16'h0000, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_INSERT, 16'h5555, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_INSERT, 16'hAAAA, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_SEARCH, 16'hAAAA, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_SEARCH, 16'h7FFF, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_SEARCH, 16'h0001, 1'b0, FROM_SHADOW},
    {stis_pkg::CMD_INSERT, 16'h7FFF, 1'b0, FROM_SHADOW}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  stis_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  stis_pkg::rsp_t rsp;

  // Shadow copy of the key table and its fill count.
  logic [15:0] sorted_keys [TABLE_DEPTH];
  int key_count = 0;

  stis_pkg::rsp_t queued_outcomes [$];
  stis_pkg::rsp_t oldest;
  int errors = 0;
  int quiet_cycles = 0;
  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;

  sorted_table_insert_search #(
    .DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Applies one transaction to the shadow table and returns its outcome.
  function automatic stis_pkg::rsp_t insert_or_find(input stis_pkg::req_t item);
    stis_pkg::rsp_t res;
    int p;
    int lo;
    int hi;
    int mid;
    res = '0;
    if (item.cmd == stis_pkg::CMD_INSERT) begin
      if (key_count >= TABLE_DEPTH) begin
        res.status = stis_pkg::ST_FULL;
      end else begin
        p = key_count;
        while (p > 0 && item.key < sorted_keys[p - 1]) begin
          sorted_keys[p] = sorted_keys[p - 1];
          p--;
        end
        sorted_keys[p] = item.key;
        key_count++;
        res.status = stis_pkg::ST_INSERTED;
        res.position = p[6:0];
      end
    end else begin
      lo = 0;
      hi = key_count;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (sorted_keys[mid] < item.key) lo = mid + 1;
        else hi = mid;
      end
      if (lo < key_count && sorted_keys[lo] == item.key) begin
        res.status = stis_pkg::ST_FOUND;
        res.position = lo[6:0];
      end else begin
        res.status = stis_pkg::ST_NOT_FOUND;
      end
    end
    res.fill_count = key_count[7:0];
    return res;
  endfunction

  // Most keys are taken from the table or sit right next to a stored key, so
  // that searches hit and inserts land among duplicates.
  function automatic stis_pkg::req_t random_item();
    stis_pkg::req_t item;
    int pick;
    item.cmd = ($urandom_range(99) < 45) ? stis_pkg::CMD_INSERT : stis_pkg::CMD_SEARCH;
    pick = $urandom_range(9);
    if (key_count != 0 && pick < 5) begin
      item.key = sorted_keys[$urandom_range(key_count - 1)];
    end else if (key_count != 0 && pick == 5) begin
      item.key = sorted_keys[$urandom_range(key_count - 1)] + ($urandom_range(1) ? 16'h0001
                                                                                  : 16'hFFFF);
    end else if (pick == 6) begin
      item.key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    end else begin
      item.key = 16'($urandom);
    end
    return item;
  endfunction

  task automatic offer(input stis_pkg::req_t item, input logic checked_here,
                       input stis_pkg::rsp_t typed);
    stis_pkg::rsp_t predicted;
    while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = insert_or_find(item);
    queued_outcomes.push_back(checked_here ? typed : predicted);
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      offer(directed_rows[i].stim, directed_rows[i].checked_here, directed_rows[i].outcome);
    end
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        1: begin
          send_gap_pct = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          recv_stall_pct = 77;
        end
        3: begin
          send_gap_pct = 25;
          recv_stall_pct = 25;
        end
        4: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
          hold_left = HOLD_OFF_CYCLES;
        end
        default: begin
          send_gap_pct = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (PHASE_ITEMS) offer(random_item(), 1'b0, FROM_SHADOW);
    end
    req_valid <= 1'b0;
    while (queued_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && queued_outcomes.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // The long hold-off is counted here so the sender keeps offering meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (queued_outcomes.size() == 0) begin
        $display("%0t: unexpected transaction, status %0d position %0d fill_count %0d",
                 $time, rsp.status, rsp.position, rsp.fill_count);
        errors++;
      end else begin
        oldest = queued_outcomes.pop_front();
        if (rsp.status !== oldest.status) begin
          $display("%0t: status expected %0d actual %0d", $time, oldest.status, rsp.status);
          errors++;
        end
        if (rsp.position !== oldest.position) begin
          $display("%0t: position expected %0d actual %0d", $time, oldest.position,
                   rsp.position);
          errors++;
        end
        if (rsp.fill_count !== oldest.fill_count) begin
          $display("%0t: fill_count expected %0d actual %0d", $time, oldest.fill_count,
                   rsp.fill_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
          $display("simulation failed");
          $finish;
        end
      end
    end
  end

endmodule

// ===== files.f =====
hw/rtl/stis_pkg.sv
hw/rtl/sorted_table_insert_search.sv
hw/rtl/stis_checker.sv
tb/sv/sorted_table_insert_search_tb.sv
